// ----- rtl/glyph_outline_shadow_defines.svh -----
`ifndef GLYPH_OUTLINE_SHADOW_DEFINES_SVH
`define GLYPH_OUTLINE_SHADOW_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define GOS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("glyph_outline_shadow: check failed");

// next-cycle implication, checked while out of reset
`define GOS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("glyph_outline_shadow: check failed");

`endif

// ----- rtl/gos_pkg.sv -----
package gos_pkg;

  localparam int unsigned RowWidthDef = 32;
  localparam int unsigned CfgW        = 6;

  localparam logic [CfgW-1:0] WidthReset  = 6'd8;
  localparam logic [CfgW-1:0] HeightReset = 6'd12;

  typedef enum logic [0:0] {
    CfgGlyphWidth  = 1'b0,
    CfgGlyphHeight = 1'b1
  } cfg_reg_e;

endpackage

// ----- rtl/glyph_outline_shadow.sv -----
// output: a row's results are registered in the result queue, which drives the master side
// throughput: one row per cycle; the final row of a glyph taller than one row yields two results,
//   drained from a four-entry result queue one per cycle while m_axis_tready is high, and input
//   stalls while fewer than two queue entries are free
// reset: asynchronous, active low; clears the row window, the row counter and the
//   queue, and loads width 8 and height 12
`include "glyph_outline_shadow_defines.svh"

module glyph_outline_shadow #(
  parameter int unsigned ROW_WIDTH = gos_pkg::RowWidthDef,
  localparam int unsigned DataW = ((ROW_WIDTH + 7) / 8) * 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // config write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [0:0]              cfg_index_i,
  input  logic [gos_pkg::CfgW-1:0] cfg_data_i,
  // source rows
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [DataW-1:0]        s_axis_tdata,   // row_bits
  // shadow rows
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [DataW-1:0]        m_axis_tdata,   // shadow_bits
  output logic                    m_axis_tlast    // glyph_end
);

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = PtrW + 1;
  localparam logic [6:0]  RowW7     = 7'(ROW_WIDTH);

  // mask of the n leftmost columns
  function automatic logic [ROW_WIDTH-1:0] left_cols(input logic [6:0] n);
    logic [ROW_WIDTH-1:0] m;
    for (int b = 0; b < ROW_WIDTH; b++) begin
      m[b] = (7'(ROW_WIDTH - 1 - b) < n);
    end
    return m;
  endfunction

  logic [gos_pkg::CfgW-1:0] width_q, height_q;
  logic [ROW_WIDTH-1:0]     older_q, newer_q;
  logic [5:0]               row_cnt_q;

  logic [ROW_WIDTH-1:0]     fifo_data_q [FifoDepth];
  logic [FifoDepth-1:0]     fifo_end_q;
  logic [PtrW-1:0]          wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]          count_q;

  logic [6:0]           eff_w, r7, h7;
  logic [5:0]           eff_h;
  logic [ROW_WIDTH-1:0] body_mask, inner_mask, x;
  logic                 inner_en, v_r, v_rm1, v_rm2, last;
  logic                 in_acc, pop;
  logic [1:0]           push_n;
  logic [ROW_WIDTH-1:0] res_first, res_a, res_b, res_0;
  logic                 end_first;

  function automatic logic [ROW_WIDTH-1:0] spread(input logic [ROW_WIDTH-1:0] bits,
                                                   input logic [ROW_WIDTH-1:0] inner,
                                                   input logic en);
    logic [ROW_WIDTH-1:0] m;
    m = bits & inner;
    return en ? (m | (m << 1) | (m >> 1)) : '0;
  endfunction

  assign cfg_ready_o = 1'b1;

  assign x      = s_axis_tdata[ROW_WIDTH-1:0];
  assign eff_w  = ({1'b0, width_q} > RowW7) ? RowW7 : {1'b0, width_q};
  assign eff_h  = (height_q == '0) ? 6'd1 : height_q;
  assign r7     = {1'b0, row_cnt_q};
  assign h7     = {1'b0, eff_h};

  assign body_mask  = left_cols(eff_w);
  assign inner_mask = left_cols(eff_w - 7'd1) & ~left_cols(7'd1);
  assign inner_en   = (eff_w >= 7'd3);

  // a source row k spreads only when 1 <= k <= h-2
  assign v_r   = inner_en && (row_cnt_q >= 6'd1) && (r7 + 7'd2 <= h7);
  assign v_rm1 = inner_en && (row_cnt_q >= 6'd2) && (r7 + 7'd1 <= h7);
  assign v_rm2 = inner_en && (row_cnt_q >= 6'd3) && (r7 <= h7);
  assign last  = (r7 + 7'd1 >= h7);

  always_comb begin
    logic [ROW_WIDTH-1:0] da, db;
    da = spread(older_q, inner_mask, v_rm2) | spread(newer_q, inner_mask, v_rm1)
       | spread(x, inner_mask, v_r);
    db = spread(newer_q, inner_mask, v_rm1) | spread(x, inner_mask, v_r);
    res_a = (newer_q | da) & ~(newer_q & body_mask);
    res_b = (x | db) & ~(x & body_mask);
    res_0 = x & ~body_mask;
  end

  assign s_axis_tready = (count_q <= CntW'(FifoDepth - 2));
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (count_q != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;

  // first row of a single-row glyph yields one result; other first rows none; later rows one, two on the final row
  always_comb begin
    if (!in_acc) begin
      push_n = 2'd0;
    end else if (row_cnt_q == '0) begin
      push_n = last ? 2'd1 : 2'd0;
    end else begin
      push_n = last ? 2'd2 : 2'd1;
    end
  end

  assign res_first = (row_cnt_q == '0) ? res_0 : res_a;
  assign end_first = (row_cnt_q == '0);

  assign m_axis_tdata = DataW'(fifo_data_q[rd_ptr_q]);
  assign m_axis_tlast = fifo_end_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= gos_pkg::WidthReset;
      height_q  <= gos_pkg::HeightReset;
      older_q   <= '0;
      newer_q   <= '0;
      row_cnt_q <= '0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      count_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (gos_pkg::cfg_reg_e'(cfg_index_i))
          gos_pkg::CfgGlyphWidth:  width_q  <= cfg_data_i;
          gos_pkg::CfgGlyphHeight: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        if (last) begin
          older_q   <= '0;
          newer_q   <= '0;
          row_cnt_q <= '0;
        end else if (row_cnt_q == '0) begin
          older_q   <= '0;
          newer_q   <= x;
          row_cnt_q <= 6'd1;
        end else begin
          older_q   <= newer_q;
          newer_q   <= x;
          row_cnt_q <= row_cnt_q + 6'd1;
        end
      end
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      count_q  <= count_q + CntW'(push_n) - CntW'(pop);
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_data_q[wr_ptr_q] <= res_first;
      fifo_end_q[wr_ptr_q]  <= end_first;
    end
    if (push_n == 2'd2) begin
      fifo_data_q[wr_ptr_q + PtrW'(1)] <= res_b;
      fifo_end_q[wr_ptr_q + PtrW'(1)]  <= 1'b1;
    end
  end

  `GOS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(FifoDepth))
  `GOS_ASSERT_NOW(a_room_on_ready, s_axis_tready, count_q <= CntW'(FifoDepth - 2))
  `GOS_ASSERT_NEXT(a_two_on_final, in_acc && last && (row_cnt_q != '0), count_q >= CntW'(2))
  `GOS_ASSERT_NEXT(a_restart, in_acc && last, row_cnt_q == '0)

endmodule

// ----- sim/glyph_outline_shadow_tb.sv -----
`timescale 1ns / 100ps

module glyph_outline_shadow_tb;

  localparam int RowW = int'(gos_pkg::RowWidthDef);

  typedef struct packed {
    logic [RowW-1:0] bits;
    logic            last;
  } shadow_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [0:0]               cfg_index_i;
  logic [gos_pkg::CfgW-1:0] cfg_data_i;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [RowW-1:0]          s_axis_tdata;   // row_bits
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [RowW-1:0]          m_axis_tdata;   // shadow_bits
  logic                     m_axis_tlast;   // glyph_end

  // predicted block state
  logic [gos_pkg::CfgW-1:0] geo_width  = gos_pkg::WidthReset;
  logic [gos_pkg::CfgW-1:0] geo_height = gos_pkg::HeightReset;
  logic [RowW-1:0]          row_above  = '0;
  logic [RowW-1:0]          row_centre = '0;
  logic [5:0]               rows_seen  = '0;

  shadow_row_t shadow_q[$];
  shadow_row_t oldest;
  int          errors    = 0;
  int          rows_sent = 0;
  bit          calm      = 1'b0;

  glyph_outline_shadow dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- shadow predictor

  function automatic int eff_width();
    return (geo_width > RowW) ? RowW : int'(geo_width);
  endfunction

  function automatic int eff_height();
    return (geo_height == 0) ? 1 : int'(geo_height);
  endfunction

  // the n leftmost columns
  function automatic logic [RowW-1:0] lead_mask(int n);
    if (n <= 0) return '0;
    if (n >= RowW) return '1;
    return ~({RowW{1'b1}} >> n);
  endfunction

  // dilation that source row k throws onto itself and its neighbors
  function automatic logic [RowW-1:0] halo(logic [RowW-1:0] bits, int k);
    logic [RowW-1:0] m;
    if (k < 1 || k + 2 > eff_height() || eff_width() < 3) return '0;
    m = bits & lead_mask(eff_width() - 1) & ~lead_mask(1);
    return m | (m << 1) | (m >> 1);
  endfunction

  function automatic logic [RowW-1:0] shade(logic [RowW-1:0] prv, bit has_prv,
                                           logic [RowW-1:0] cur, logic [RowW-1:0] below,
                                           bit has_below, int r);
    logic [RowW-1:0] d;
    d = halo(cur, r);
    if (has_prv && r >= 1) d |= halo(prv, r - 1);
    if (has_below) d |= halo(below, r + 1);
    return (cur | d) & ~(cur & lead_mask(eff_width()));
  endfunction

  function automatic void push_shadow(logic [RowW-1:0] bits, logic last);
    shadow_row_t e;
    e.bits = bits;
    e.last = last;
    shadow_q.push_back(e);
  endfunction

  function automatic void take_row(logic [RowW-1:0] x);
    int r;
    bit fin;
    r   = int'(rows_seen);
    fin = (r + 1 >= eff_height());
    if (r == 0 && !fin) begin
      row_above  = '0;
      row_centre = x;
      rows_seen  = 6'd1;
    end else if (r == 0) begin
      push_shadow(shade('0, 1'b0, x, '0, 1'b0, 0), 1'b1);
      row_above  = '0;
      row_centre = '0;
      rows_seen  = '0;
    end else begin
      push_shadow(shade(row_above, r >= 2, row_centre, x, 1'b1, r - 1), 1'b0);
      if (fin) begin
        push_shadow(shade(row_centre, 1'b1, x, '0, 1'b0, r), 1'b1);
        row_above  = '0;
        row_centre = '0;
        rows_seen  = '0;
      end else begin
        row_above  = row_centre;
        row_centre = x;
        rows_seen  = 6'(r + 1);
      end
    end
  endfunction

  // config, input and output handshakes are all seen here, in that order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == gos_pkg::CfgGlyphWidth) geo_width = cfg_data_i;
        else geo_height = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) take_row(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (shadow_q.size() == 0) begin
          $display("%0t: unexpected shadow row, expected none, got %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          oldest = shadow_q.pop_front();
          if (m_axis_tdata !== oldest.bits) begin
            $display("%0t: shadow_bits expected %h got %h", $time, oldest.bits, m_axis_tdata);
            errors++;
          end
          if (m_axis_tlast !== oldest.last) begin
            $display("%0t: glyph_end expected %b got %b", $time, oldest.last, m_axis_tlast);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk_i) m_axis_tready <= calm || ($urandom_range(99) >= 18);

  // ---------------------------------------------------------------- drivers

  // returns on the falling edge after the handshake with tvalid still high,
  // so the caller either sends again or calls drain at once
  task automatic send_row(logic [RowW-1:0] bits);
    while (!calm && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bits;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rows_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (shadow_q.size() != 0) @(negedge clk_i);
    // a first row leaves nothing behind, so wait on past an empty queue before returning
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(gos_pkg::cfg_reg_e idx, logic [gos_pkg::CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_geometry(logic [gos_pkg::CfgW-1:0] wid, logic [gos_pkg::CfgW-1:0] hgt);
    write_reg(gos_pkg::CfgGlyphWidth, wid);
    write_reg(gos_pkg::CfgGlyphHeight, hgt);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [RowW-1:0] pick_row();
    case ($urandom_range(7))
      0: return $urandom & $urandom & $urandom;
      1: return $urandom | $urandom;
      2: return 32'h1 << $urandom_range(31);
      3: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [gos_pkg::CfgW-1:0] pick_limit();
    case ($urandom_range(5))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd2;
      3: return 6'd32;
      4: return 6'd33;
      default: return 6'd63;
    endcase
  endfunction

  function automatic logic [gos_pkg::CfgW-1:0] pick_width();
    case ($urandom_range(7))
      0: return pick_limit();
      1: return 6'($urandom_range(63));
      default: return 6'($urandom_range(3, 32));
    endcase
  endfunction

  // tall glyphs are kept rare
  function automatic logic [gos_pkg::CfgW-1:0] pick_height();
    case ($urandom_range(9))
      0: return pick_limit();
      1: return 6'($urandom_range(13, 40));
      default: return 6'($urandom_range(1, 12));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_default_glyph();
    logic [RowW-1:0] rows [12];
    rows = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
             32'h7E00_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h3C00_0000,
             32'hFF00_0000, 32'h01FF_FFFF, 32'h1800_0000, 32'hFFFF_FFFF};
    foreach (rows[i]) send_row(rows[i]);
    drain();
  endtask

  task automatic test_single_row();
    set_geometry(6'd32, 6'd1);
    send_row(32'hFFFF_FFFF);
    send_row(32'h5A5A_5A5A);
    drain();
    // zero height acts as one
    set_geometry(6'd32, 6'd0);
    send_row(32'h1234_5678);
    drain();
  endtask

  task automatic test_narrow_width();
    set_geometry(6'd2, 6'd3);
    send_row(32'hFFFF_FFFF);
    send_row(32'hC000_0000);
    send_row(32'h7FFF_FFFE);
    drain();
    set_geometry(6'd0, 6'd1);
    send_row(32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_wide_width();
    set_geometry(6'd63, 6'd4);
    send_row(32'h0000_0000);
    send_row(32'h4000_0002);
    send_row(32'hFFFF_FFFF);
    send_row(32'h8000_0001);
    drain();
  endtask

  task automatic test_height_change();
    set_geometry(6'd32, 6'd32);
    send_row(32'h0FF0_0FF0);
    send_row(32'h7FFF_FFFE);
    send_row(32'h0001_8000);
    drain();
    // row index already past the new height, so the next row closes the glyph
    set_geometry(6'd32, 6'd2);
    send_row(32'hF0F0_F0F0);
    drain();
  endtask

  task automatic test_random_glyphs();
    logic [gos_pkg::CfgW-1:0] wid;
    logic [gos_pkg::CfgW-1:0] hgt;
    int                       rows;
    int                       glyphs;
    while (rows_sent < 1330) begin
      calm   = (rows_sent >= 500 && rows_sent < 750);
      wid    = pick_width();
      hgt    = pick_height();
      set_geometry(wid, hgt);
      glyphs = int'($urandom_range(1, 4));
      for (int g = 0; g < glyphs; g++) begin
        rows = (hgt == 0) ? 1 : int'(hgt);
        // now and then cut the last glyph short
        if (g == glyphs - 1 && $urandom_range(7) == 0) rows = int'($urandom_range(1, rows));
        repeat (rows) send_row(pick_row());
      end
      drain();
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = gos_pkg::CfgGlyphWidth;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_default_glyph();
    test_single_row();
    test_narrow_width();
    test_wide_width();
    test_height_change();
    test_random_glyphs();
    drain();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
